// File: rtl/orbital_phase_angle_check_assert.svh
// Assertion macros shared by the phase angle check checker.
`ifndef ORBITAL_PHASE_ANGLE_CHECK_ASSERT_SVH
`define ORBITAL_PHASE_ANGLE_CHECK_ASSERT_SVH

// Concurrent check, off while reset is high.
`define OPAC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define OPAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/opac_pkg.sv
// Shared types, constants and helpers of the phase angle check.
`timescale 1ns / 1ps
package opac_pkg;

   localparam int CORDIC_STEPS = 31;
   localparam int SQRT_STEPS   = 32;

   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

   localparam logic [29:0] ARC_TAB [CORDIC_STEPS] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1
   };

   typedef enum logic [1:0] {
      CSR_PHASE_GOAL   = 2'd0,
      CSR_PHASE_WINDOW = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic               vld;
      logic               zero;
      logic [63:0]        rem;
      logic [63:0]        root;
      logic signed [63:0] x;
   } sqrt_lane_type;

   typedef struct packed {
      logic               vld;
      logic               force_en;
      logic               force_pi;
      logic               base;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] z;
   } arc_lane_type;

   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   // Bring the leading one of m to bit 29.
   function automatic logic [63:0] fit_apply(input logic [63:0] m, input logic [5:0] pos);
      logic [63:0] r;
      if (pos >= 6'd30) begin
         r = m >> (pos - 6'd29);
      end else begin
         r = m << (6'd29 - pos);
      end
      return r;
   endfunction

endpackage

// File: rtl/orbital_phase_angle_check.sv
// Top level of the orbital phase angle check.
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | body xyz, ship xyz
//   rsp     | out | rsp_tvalid/rsp_tready  | phase_angle, reached in tuser
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
// One word per cycle while the skid entry is empty; stages: front stages, 32 root
// cells, the operand stage, 31 CORDIC cells, one rounding stage and the output register.
// Reset clears all valid bits and loads the register defaults.
// The whole pipe stalls only when the output and its skid entry are both full.
`timescale 1ns / 1ps
module orbital_phase_angle_check
   import opac_pkg::*;
#(
   parameter int COORD_BITS      = 24,
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // body_x, body_y, body_z, ship_x, ship_y, ship_z
   input  logic [((6 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // phase_angle
   output logic [((ANGLE_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // reached
   output logic rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [ANGLE_FRAC_BITS + 1:0] csr_data
);

   localparam int CB     = COORD_BITS;
   localparam int AB     = ANGLE_FRAC_BITS + 2;
   localparam int RSP_W  = ((ANGLE_FRAC_BITS + 2 + 7) / 8) * 8;
   localparam int DROP   = 30 - ANGLE_FRAC_BITS;
   localparam logic [34:0] HALF = 35'd1 << (29 - ANGLE_FRAC_BITS);
   localparam logic [34:0] PIMAX_W = (35'(PI_Q30) + HALF) >> DROP;
   localparam logic [AB-1:0] PIMAX = AB'(PIMAX_W);
   localparam logic [ANGLE_FRAC_BITS-1:0] WINDOW_RST =
      ANGLE_FRAC_BITS'(((1 << ANGLE_FRAC_BITS) + 500) / 1000);

   logic adv;

   // configuration
   logic [AB-1:0]              goal_ff;
   logic [ANGLE_FRAC_BITS-1:0] window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff   <= '0;
         window_ff <= WINDOW_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PHASE_GOAL:   goal_ff   <= csr_data[AB-1:0];
            CSR_PHASE_WINDOW: window_ff <= csr_data[ANGLE_FRAC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // front stage valid and zero flags
   logic v_ff [9];
   logic v_in [9];
   logic zr_ff [2:8];

   // stage 0: capture, form offset
   logic signed [CB-1:0] s0_a_ff [3];
   logic signed [CB:0]   s0_b_ff [3];
   logic signed [CB-1:0] s0_a_in [3];
   logic signed [CB:0]   s0_b_in [3];
   logic [CB-1:0]        s0_s    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_a_in[i] = req_tdata[i*CB +: CB];
         s0_s[i]    = req_tdata[(3+i)*CB +: CB];
         s0_b_in[i] = {s0_s[i][CB-1], s0_s[i]} - {s0_a_in[i][CB-1], s0_a_in[i]};
      end
   end

   // stage 1: magnitudes and maxima
   logic [CB:0] am [3];
   logic [CB:0] bm [3];
   logic signed [CB-1:0] s1_a_ff [3];
   logic signed [CB:0]   s1_b_ff [3];
   logic [CB:0] s1_amax_ff, s1_bmax_ff, s1_amax_in, s1_bmax_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         am[i] = s0_a_ff[i][CB-1] ? -{s0_a_ff[i][CB-1], s0_a_ff[i]}
                                  : {s0_a_ff[i][CB-1], s0_a_ff[i]};
         bm[i] = s0_b_ff[i][CB] ? -s0_b_ff[i] : s0_b_ff[i];
      end
      s1_amax_in = am[0];
      s1_bmax_in = bm[0];
      for (int i = 1; i < 3; i++) begin
         if (am[i] > s1_amax_in) s1_amax_in = am[i];
         if (bm[i] > s1_bmax_in) s1_bmax_in = bm[i];
      end
   end

   // stage 2: scale both vectors to a leading one at bit 29
   logic [CB:0]  am1 [3];
   logic [CB:0]  bm1 [3];
   logic [5:0]   apos, bpos;
   logic [63:0]  afit [3];
   logic [63:0]  bfit [3];
   logic signed [30:0] s2_na_ff [3];
   logic signed [30:0] s2_nb_ff [3];
   logic signed [30:0] s2_na_in [3];
   logic signed [30:0] s2_nb_in [3];
   logic zr2_in;

   always_comb begin
      apos = msb_pos(64'(s1_amax_ff));
      bpos = msb_pos(64'(s1_bmax_ff));
      for (int i = 0; i < 3; i++) begin
         am1[i] = s1_a_ff[i][CB-1] ? -{s1_a_ff[i][CB-1], s1_a_ff[i]}
                                   : {s1_a_ff[i][CB-1], s1_a_ff[i]};
         bm1[i] = s1_b_ff[i][CB] ? -s1_b_ff[i] : s1_b_ff[i];
         afit[i] = fit_apply(64'(am1[i]), apos);
         bfit[i] = fit_apply(64'(bm1[i]), bpos);
         s2_na_in[i] = s1_a_ff[i][CB-1] ? -{1'b0, afit[i][29:0]} : {1'b0, afit[i][29:0]};
         s2_nb_in[i] = s1_b_ff[i][CB] ? -{1'b0, bfit[i][29:0]} : {1'b0, bfit[i][29:0]};
      end
      zr2_in = (s1_amax_ff == '0) || (s1_bmax_ff == '0);
   end

   // stage 3: products
   logic signed [61:0] s3_p_ff [9];
   logic signed [61:0] s3_p_in [9];

   always_comb begin
      s3_p_in[0] = s2_na_ff[1] * s2_nb_ff[2];
      s3_p_in[1] = s2_na_ff[2] * s2_nb_ff[1];
      s3_p_in[2] = s2_na_ff[2] * s2_nb_ff[0];
      s3_p_in[3] = s2_na_ff[0] * s2_nb_ff[2];
      s3_p_in[4] = s2_na_ff[0] * s2_nb_ff[1];
      s3_p_in[5] = s2_na_ff[1] * s2_nb_ff[0];
      s3_p_in[6] = s2_na_ff[0] * s2_nb_ff[0];
      s3_p_in[7] = s2_na_ff[1] * s2_nb_ff[1];
      s3_p_in[8] = s2_na_ff[2] * s2_nb_ff[2];
   end

   // stage 4: cross and dot products
   logic signed [62:0] s4_c_ff [3];
   logic signed [62:0] s4_c_in [3];
   logic signed [63:0] s4_dot_ff, s4_dot_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_c_in[i] = 63'(s3_p_ff[2*i]) - 63'(s3_p_ff[2*i+1]);
      end
      s4_dot_in = 64'(s3_p_ff[6]) + 64'(s3_p_ff[7]) + 64'(s3_p_ff[8]);
   end

   // stage 5: cross magnitudes
   logic [62:0] s5_cm_ff [3];
   logic [62:0] s5_cm_in [3];
   logic [62:0] s5_max_ff, s5_max_in;
   logic signed [63:0] s5_dot_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_cm_in[i] = s4_c_ff[i][62] ? -s4_c_ff[i] : s4_c_ff[i];
      end
      s5_max_in = s5_cm_in[0];
      for (int i = 1; i < 3; i++) begin
         if (s5_cm_in[i] > s5_max_in) s5_max_in = s5_cm_in[i];
      end
   end

   // stage 6: common scale for cross and dot
   logic [5:0]  cpos, csh;
   logic [63:0] dmag, xmag;
   logic [30:0] s6_u_ff [3];
   logic [30:0] s6_u_in [3];
   logic signed [63:0] s6_x_ff, s6_x_in;
   logic [62:0] ush [3];

   always_comb begin
      cpos = msb_pos(64'(s5_max_ff));
      csh  = (cpos >= 6'd31) ? cpos - 6'd30 : 6'd0;
      for (int i = 0; i < 3; i++) begin
         ush[i]     = s5_cm_ff[i] >> csh;
         s6_u_in[i] = ush[i][30:0];
      end
      dmag    = s5_dot_ff[63] ? -s5_dot_ff : s5_dot_ff;
      xmag    = dmag >> csh;
      s6_x_in = s5_dot_ff[63] ? -xmag : xmag;
   end

   // stage 7: squares, stage 8: sum
   logic [61:0] s7_sq_ff [3];
   logic [61:0] s7_sq_in [3];
   logic signed [63:0] s7_x_ff;
   logic [63:0] s8_sum_ff, s8_sum_in;
   logic signed [63:0] s8_x_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_sq_in[i] = 62'(s6_u_ff[i]) * 62'(s6_u_ff[i]);
      end
      s8_sum_in = 64'(s7_sq_ff[0]) + 64'(s7_sq_ff[1]) + 64'(s7_sq_ff[2]);
   end

   always_comb begin
      v_in[0] = req_tvalid;
      for (int i = 1; i < 9; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < 9; i++) v_ff[i] <= v_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_a_ff    <= s0_a_in;
         s0_b_ff    <= s0_b_in;
         s1_a_ff    <= s0_a_ff;
         s1_b_ff    <= s0_b_ff;
         s1_amax_ff <= s1_amax_in;
         s1_bmax_ff <= s1_bmax_in;
         s2_na_ff   <= s2_na_in;
         s2_nb_ff   <= s2_nb_in;
         zr_ff[2]   <= zr2_in;
         for (int i = 3; i < 9; i++) zr_ff[i] <= zr_ff[i-1];
         s3_p_ff    <= s3_p_in;
         s4_c_ff    <= s4_c_in;
         s4_dot_ff  <= s4_dot_in;
         s5_cm_ff   <= s5_cm_in;
         s5_max_ff  <= s5_max_in;
         s5_dot_ff  <= s4_dot_ff;
         s6_u_ff    <= s6_u_in;
         s6_x_ff    <= s6_x_in;
         s7_sq_ff   <= s7_sq_in;
         s7_x_ff    <= s6_x_ff;
         s8_sum_ff  <= s8_sum_in;
         s8_x_ff    <= s7_x_ff;
      end
   end

   // square root chain
   sqrt_lane_type sq_lane [SQRT_STEPS+1];

   always_comb begin
      sq_lane[0].vld  = v_ff[8];
      sq_lane[0].zero = zr_ff[8];
      sq_lane[0].rem  = s8_sum_ff;
      sq_lane[0].root = '0;
      sq_lane[0].x    = s8_x_ff;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      opac_sqrt_cell #(.STEP(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .lane_in (sq_lane[k]),
         .lane_out(sq_lane[k+1])
      );
   end

   // stage 9: arctangent operands
   sqrt_lane_type sq_end;
   logic [63:0] r9, xm9;
   logic        neg9;
   logic [63:0] s9_ux_ff, s9_uy_ff, s9_mx_ff, s9_ux_in, s9_uy_in, s9_mx_in;
   logic        s9_neg_ff, s9_fen_ff, s9_fpi_ff, s9_v_ff;
   logic        s9_fen_in, s9_fpi_in;

   always_comb begin
      sq_end    = sq_lane[SQRT_STEPS];
      r9        = sq_end.root;
      neg9      = sq_end.x[63];
      xm9       = neg9 ? -sq_end.x : sq_end.x;
      s9_ux_in  = neg9 ? r9 : xm9;
      s9_uy_in  = neg9 ? xm9 : r9;
      s9_mx_in  = (s9_ux_in > s9_uy_in) ? s9_ux_in : s9_uy_in;
      s9_fen_in = sq_end.zero || (r9 == '0);
      s9_fpi_in = !sq_end.zero && neg9;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else if (adv) begin
         s9_v_ff <= sq_end.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_ux_ff  <= s9_ux_in;
         s9_uy_ff  <= s9_uy_in;
         s9_mx_ff  <= s9_mx_in;
         s9_neg_ff <= neg9;
         s9_fen_ff <= s9_fen_in;
         s9_fpi_ff <= s9_fpi_in;
      end
   end

   // CORDIC chain
   arc_lane_type arc_lane [CORDIC_STEPS+1];
   logic [5:0]   mpos;
   logic [63:0]  fx, fy;

   always_comb begin
      mpos = msb_pos(s9_mx_ff);
      fx   = fit_apply(s9_ux_ff, mpos);
      fy   = fit_apply(s9_uy_ff, mpos);
      arc_lane[0].vld      = s9_v_ff;
      arc_lane[0].force_en = s9_fen_ff;
      arc_lane[0].force_pi = s9_fpi_ff;
      arc_lane[0].base     = s9_neg_ff;
      arc_lane[0].cx       = {4'b0, fx[29:0]};
      arc_lane[0].cy       = {4'b0, fy[29:0]};
      arc_lane[0].z        = '0;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      opac_cordic_cell #(.STEP(k)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .lane_in (arc_lane[k]),
         .lane_out(arc_lane[k+1])
      );
   end

   // stage 11: offset, clamp, round
   arc_lane_type       arc_end;
   logic signed [34:0] zs, zc;
   logic [34:0]        rnd;
   logic [AB-1:0]      ang_ff, ang_in;
   logic               ang_v_ff;

   always_comb begin
      arc_end = arc_lane[CORDIC_STEPS];
      zs = 35'(arc_end.z) + (arc_end.base ? HALF_PI_Q30 : 35'sd0);
      if (zs < 35'sd0) begin
         zc = '0;
      end else if (zs > PI_Q30) begin
         zc = PI_Q30;
      end else begin
         zc = zs;
      end
      rnd = (35'(zc) + HALF) >> DROP;
      if (arc_end.force_en) begin
         ang_in = arc_end.force_pi ? PIMAX : '0;
      end else begin
         ang_in = AB'(rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_v_ff <= 1'b0;
      end else if (adv) begin
         ang_v_ff <= arc_end.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff <= ang_in;
      end
   end

   // match flag and output buffer with skid entry
   logic [AB-1:0] diff;
   logic          reached;
   logic          push, pop;
   logic          out_vld_ff, skid_vld_ff;
   logic [AB-1:0] out_ang_ff, skid_ang_ff;
   logic          out_hit_ff, skid_hit_ff;

   always_comb begin
      diff    = (ang_ff > goal_ff) ? ang_ff - goal_ff : goal_ff - ang_ff;
      reached = diff < AB'(window_ff);
   end

   assign adv  = !skid_vld_ff;
   assign push = adv && ang_v_ff;
   assign pop  = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_ang_ff <= skid_ang_ff;
            out_hit_ff <= skid_hit_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_ang_ff <= ang_ff;
            skid_hit_ff <= reached;
         end else begin
            out_ang_ff <= ang_ff;
            out_hit_ff <= reached;
         end
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'(out_ang_ff);
   assign rsp_tuser  = out_hit_ff;

endmodule

// File: rtl/opac_sqrt_cell.sv
// One digit step of the pipelined integer square root.
`timescale 1ns / 1ps
module opac_sqrt_cell
   import opac_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  sqrt_lane_type lane_in,
   output sqrt_lane_type lane_out
);

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   sqrt_lane_type lane_ff;
   sqrt_lane_type lane_in_n;
   logic [63:0]   trial;

   always_comb begin
      lane_in_n = lane_in;
      trial     = lane_in.root + BIT;
      if (lane_in.rem >= trial) begin
         lane_in_n.rem  = lane_in.rem - trial;
         lane_in_n.root = (lane_in.root >> 1) + BIT;
      end else begin
         lane_in_n.root = lane_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.vld <= 1'b0;
      end else if (adv) begin
         lane_ff <= lane_in_n;
      end
   end

   assign lane_out = lane_ff;

endmodule

// File: rtl/opac_cordic_cell.sv
// One vectoring rotation of the pipelined arctangent.
`timescale 1ns / 1ps
module opac_cordic_cell
   import opac_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  arc_lane_type lane_in,
   output arc_lane_type lane_out
);

   arc_lane_type lane_ff;
   arc_lane_type lane_in_n;
   logic signed [33:0] dx;
   logic signed [33:0] dy;

   always_comb begin
      lane_in_n = lane_in;
      dx = lane_in.cx >>> STEP;
      dy = lane_in.cy >>> STEP;
      if (lane_in.cy > 34'sd0) begin
         lane_in_n.cx = lane_in.cx + dy;
         lane_in_n.cy = lane_in.cy - dx;
         lane_in_n.z  = lane_in.z + $signed({4'b0, ARC_TAB[STEP]});
      end else begin
         lane_in_n.cx = lane_in.cx - dy;
         lane_in_n.cy = lane_in.cy + dx;
         lane_in_n.z  = lane_in.z - $signed({4'b0, ARC_TAB[STEP]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.vld <= 1'b0;
      end else if (adv) begin
         lane_ff <= lane_in_n;
      end
   end

   assign lane_out = lane_ff;

endmodule

// File: rtl/opac_checker.sv
// Port-level checks of the phase angle check, bound to the top level.
`timescale 1ns / 1ps
`include "orbital_phase_angle_check_assert.svh"
module opac_checker
   import opac_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((ANGLE_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic rsp_tuser
);

   localparam int AB   = ANGLE_FRAC_BITS + 2;
   localparam int DROP = 30 - ANGLE_FRAC_BITS;
   localparam logic [34:0] HALF  = 35'd1 << (29 - ANGLE_FRAC_BITS);
   localparam logic [34:0] PIMAX = (35'(PI_Q30) + HALF) >> DROP;

   `OPAC_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "result word changed while stalled")

   `OPAC_ASSERT_ALWAYS(a_rsp_reset, clock,
      reset |=> !rsp_tvalid,
      "result valid right after reset")

   `OPAC_ASSERT(a_angle_range, clock, reset,
      rsp_tvalid |-> 35'(rsp_tdata[AB-1:0]) <= PIMAX,
      "phase angle above pi")

   `OPAC_ASSERT(a_ready_stall, clock, reset,
      !req_tready |=> $past(rsp_tvalid) || rsp_tvalid,
      "input stalled with no result pending")

endmodule

bind orbital_phase_angle_check opac_checker #(
   .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_opac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
